@@ sv/fdl_pkg.sv @@
// Package for the fractional delay line: field widths and parameter defaults for
// the core, the interpolator and the checker, and the interpolator's sample bias.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fdl_pkg;

    localparam int SAMPLE_W       = 24;
    localparam int DELAY_W        = 24;
    localparam int CFG_LEN_W      = 17;

    localparam int TAPE_DEPTH_DEF = 65536;
    localparam int FRAC_BITS_DEF  = 8;

    // Length register value after reset.
    localparam logic [CFG_LEN_W-1:0] TAPE_LEN_RESET = 17'h10000;

    // XOR with this maps a signed Q1.23 sample onto an offset-binary value.
    localparam logic [SAMPLE_W-1:0] SAMPLE_BIAS = 24'h800000;

endpackage

`default_nettype wire

@@ sv/fdl_interp.sv @@
// Linear interpolation stage of the fractional delay line: two weighted
// products, then rounding into the output register.
// Depends on fdl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdl_interp #(
    parameter int FRAC_BITS = fdl_pkg::FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [fdl_pkg::SAMPLE_W-1:0] i_tap_a,
    input  wire  [fdl_pkg::SAMPLE_W-1:0] i_tap_b,
    input  wire  [FRAC_BITS-1:0]         i_frac,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [fdl_pkg::SAMPLE_W-1:0] o_data
);

    localparam int WGT_W  = FRAC_BITS + 1;
    localparam int PROD_W = fdl_pkg::SAMPLE_W + WGT_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [WGT_W-1:0] WGT_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic                         r_prod_valid;
    logic [PROD_W-1:0]            r_prod_a;
    logic [PROD_W-1:0]            r_prod_b;
    logic                         r_out_valid;
    logic [fdl_pkg::SAMPLE_W-1:0] r_out_data;

    logic                         out_go;
    logic                         prod_ready;
    logic [fdl_pkg::SAMPLE_W-1:0] ua;
    logic [fdl_pkg::SAMPLE_W-1:0] ub;
    logic [WGT_W-1:0]             wgt_a;
    logic [WGT_W-1:0]             wgt_b;
    logic [PROD_W-1:0]            n_prod_a;
    logic [PROD_W-1:0]            n_prod_b;
    logic [SUM_W-1:0]             sum;
    logic [fdl_pkg::SAMPLE_W-1:0] n_out_data;

    assign out_go     = !r_out_valid || i_ready;
    assign prod_ready = !r_prod_valid || out_go;
    assign o_ready    = prod_ready;

    always_comb begin
        ua       = i_tap_a ^ fdl_pkg::SAMPLE_BIAS;
        ub       = i_tap_b ^ fdl_pkg::SAMPLE_BIAS;
        wgt_b    = {1'b0, i_frac};
        wgt_a    = WGT_ONE - wgt_b;
        n_prod_a = PROD_W'(ua) * PROD_W'(wgt_a);
        n_prod_b = PROD_W'(ub) * PROD_W'(wgt_b);
        // Half an LSB of the result rounds to nearest, ties upward.
        sum      = SUM_W'(r_prod_a) + SUM_W'(r_prod_b)
                 + (SUM_W'(1) << (FRAC_BITS - 1));
        n_out_data = sum[FRAC_BITS +: fdl_pkg::SAMPLE_W] ^ fdl_pkg::SAMPLE_BIAS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (prod_ready) begin
                r_prod_valid <= i_valid;
            end
            if (out_go) begin
                r_out_valid <= r_prod_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (prod_ready) begin
            r_prod_a <= n_prod_a;
            r_prod_b <= n_prod_b;
        end
        if (out_go) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

`default_nettype wire

@@ sv/fractional_delay_line_core.sv @@
// Top level of the fractional delay line: tape memory, write pointer,
// read address pipeline and the interpolator.
// Depends on fdl_pkg and fdl_interp.
//
// Usage:
// Each input request carries a sample and a delay with FRAC_BITS fraction
// bits. The block reads the tape at the floor and the ceiling of the delay
// behind the write pointer, returns their linear interpolation on the output
// channel and then records the sample and advances the pointer, wrapping at
// the configured tape length. Delays beyond the tape saturate.
// The configuration channel writes the tape length (clamped to 2..TAPE_DEPTH)
// and moves the write pointer back to the start; it is always ready.
// A request passes the read address pipeline, then the interpolator's product
// and output registers. Unless the receiver stalls, one request is accepted every
// cycle; the tape is a single memory with two read ports and one write port, and
// each request reads and writes it in the same cycle. After reset the tape is
// cleared one entry per cycle; the input channel is not ready during that pass.
// When the receiver stalls, results queue in the pipeline stages and the
// output register; input ready falls only once every stage is full.
`timescale 1ns / 1ps
`default_nettype none

module fractional_delay_line_core #(
    parameter int TAPE_DEPTH = fdl_pkg::TAPE_DEPTH_DEF,
    parameter int FRAC_BITS  = fdl_pkg::FRAC_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire  [fdl_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire  [fdl_pkg::DELAY_W-1:0]   i_delay,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [fdl_pkg::SAMPLE_W-1:0]  o_delayed_sample,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [fdl_pkg::CFG_LEN_W-1:0] i_cfg_tape_length
);

    localparam int ADDR_W  = $clog2(TAPE_DEPTH);
    localparam int LEN_W   = ADDR_W + 1;
    localparam int BACK_W  = ADDR_W + 1;
    localparam int DIFF_W  = ADDR_W + 2;
    localparam int MAXD_W  = ADDR_W + FRAC_BITS;
    localparam int DLY_W   = fdl_pkg::DELAY_W;
    localparam int WHOLE_W = DLY_W - FRAC_BITS;
    localparam int CMP_W   = (DLY_W > MAXD_W) ? DLY_W : MAXD_W;
    localparam int CLEN_W  = (fdl_pkg::CFG_LEN_W > LEN_W) ? fdl_pkg::CFG_LEN_W : LEN_W;
    localparam int SW      = fdl_pkg::SAMPLE_W;

    function automatic logic [LEN_W-1:0] f_eff_len(
        input logic [fdl_pkg::CFG_LEN_W-1:0] value
    );
        logic [CLEN_W-1:0] v;
        v = CLEN_W'(value);
        if (v < CLEN_W'(2)) begin
            return LEN_W'(2);
        end else if (v > CLEN_W'(TAPE_DEPTH)) begin
            return LEN_W'(TAPE_DEPTH);
        end
        return LEN_W'(v);
    endfunction

    function automatic logic [ADDR_W-1:0] f_ring_back(
        input logic [ADDR_W-1:0] pos,
        input logic [BACK_W-1:0] back,
        input logic [LEN_W-1:0]  len
    );
        logic [DIFF_W-1:0] diff;
        diff = DIFF_W'(pos) - DIFF_W'(back);
        if (diff[DIFF_W-1]) begin
            diff = diff + DIFF_W'(len);
        end
        return diff[ADDR_W-1:0];
    endfunction

    // Tape memory.
    logic [SW-1:0] mem_tape [TAPE_DEPTH];

    // Configuration and pointer state.
    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_len_m1;
    logic [ADDR_W-1:0] r_widx;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // Stage 1: accepted request with saturated delay.
    logic              r1_valid;
    logic [SW-1:0]     r1_sample;
    logic [DLY_W-1:0]  r1_delay;
    logic [ADDR_W-1:0] r1_w;

    // Stage 2: tape addresses.
    logic                 r2_valid;
    logic [SW-1:0]        r2_sample;
    logic [ADDR_W-1:0]    r2_w;
    logic [ADDR_W-1:0]    r2_ia;
    logic [ADDR_W-1:0]    r2_ib;
    logic [FRAC_BITS-1:0] r2_frac;

    // Stage 3: tape read data.
    logic                 r3_valid;
    logic [SW-1:0]        r3_a;
    logic [SW-1:0]        r3_b;
    logic [FRAC_BITS-1:0] r3_frac;

    logic                 rdy1;
    logic                 rdy2;
    logic                 rdy3;
    logic                 rdy4;
    logic                 in_fire;
    logic [LEN_W-1:0]     n_len;
    logic [ADDR_W-1:0]    n_widx;
    logic [MAXD_W-1:0]    max_delay;
    logic [DLY_W-1:0]     n_delay;
    logic [WHOLE_W-1:0]   whole;
    logic [FRAC_BITS-1:0] frac;
    logic [BACK_W-1:0]    back_a;
    logic [BACK_W-1:0]    back_b;
    logic [ADDR_W-1:0]    n_ia;
    logic [ADDR_W-1:0]    n_ib;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [SW-1:0]        mem_wdata;

    assign rdy3       = !r3_valid || rdy4;
    assign rdy2       = !r2_valid || rdy3;
    assign rdy1       = !r1_valid || rdy2;
    assign o_in_ready = rdy1 && !r_clr_busy;
    assign in_fire    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_len     = f_eff_len(i_cfg_tape_length);
        n_widx    = (r_widx == r_len_m1) ? '0 : r_widx + ADDR_W'(1);
        max_delay = {r_len_m1, {FRAC_BITS{1'b0}}};
        if (CMP_W'(i_delay) > CMP_W'(max_delay)) begin
            n_delay = DLY_W'(max_delay);
        end else begin
            n_delay = i_delay;
        end

        whole  = r1_delay[DLY_W-1:FRAC_BITS];
        frac   = r1_delay[FRAC_BITS-1:0];
        back_a = BACK_W'(whole);
        back_b = back_a + BACK_W'(1);
        n_ia   = f_ring_back(r1_w, back_a, r_len);
        // With no fraction both taps are the same sample.
        n_ib   = (frac != '0) ? f_ring_back(r1_w, back_b, r_len) : n_ia;

        mem_we    = r_clr_busy || (r2_valid && rdy3);
        mem_waddr = r_clr_busy ? r_clr_addr : r2_w;
        mem_wdata = r_clr_busy ? '0 : r2_sample;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= f_eff_len(fdl_pkg::TAPE_LEN_RESET);
            r_len_m1   <= ADDR_W'(f_eff_len(fdl_pkg::TAPE_LEN_RESET) - LEN_W'(1));
            r_widx     <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r1_valid   <= 1'b0;
            r2_valid   <= 1'b0;
            r3_valid   <= 1'b0;
        end else begin
            priority if (i_cfg_valid) begin
                r_len    <= n_len;
                r_len_m1 <= ADDR_W'(n_len - LEN_W'(1));
                r_widx   <= '0;
            end else if (in_fire) begin
                r_widx <= n_widx;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(TAPE_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (rdy1) begin
                r1_valid <= in_fire;
            end
            if (rdy2) begin
                r2_valid <= r1_valid;
            end
            if (rdy3) begin
                r3_valid <= r2_valid;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_sample <= i_sample;
            r1_delay  <= n_delay;
            r1_w      <= r_widx;
        end
        if (rdy2) begin
            r2_sample <= r1_sample;
            r2_w      <= r1_w;
            r2_ia     <= n_ia;
            r2_ib     <= n_ib;
            r2_frac   <= frac;
        end
        if (rdy3) begin
            r3_frac <= r2_frac;
        end
    end

    // Reads see the tape before this request's own write; later requests
    // read in later cycles, so they always see earlier writes.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_tape[mem_waddr] <= mem_wdata;
        end
        if (rdy3) begin
            r3_a <= mem_tape[r2_ia];
            r3_b <= mem_tape[r2_ib];
        end
    end

    fdl_interp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_valid),
        .o_ready (rdy4),
        .i_tap_a (r3_a),
        .i_tap_b (r3_b),
        .i_frac  (r3_frac),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_delayed_sample)
    );

endmodule

`default_nettype wire

@@ sv/fdl_checker.sv @@
// Port-level checker for the fractional delay line and its bind to the
// top level.
// Depends on fdl_pkg and fractional_delay_line_core.
`timescale 1ns / 1ps
`default_nettype none

module fdl_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_valid,
    input wire                          o_in_ready,
    input wire                          o_out_valid,
    input wire                          i_out_ready,
    input wire [fdl_pkg::SAMPLE_W-1:0]  o_delayed_sample
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_delayed_sample))
        else $error("result changed or dropped while stalled");

    // The tape clearing pass keeps the input closed right after reset.
    a_clear_blocks_input: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready during tape clear");

    // The pipeline is empty after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // With the receiver ready throughout, a request comes out as a valid result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_out_ready) ##1 i_out_ready ##1 i_out_ready
            ##1 i_out_ready ##1 i_out_ready |=> o_out_valid)
        else $error("result missing after pipeline latency");

endmodule

bind fractional_delay_line_core fdl_checker u_fdl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_delayed_sample (o_delayed_sample)
);

`default_nettype wire

@@ dv/tb_fractional_delay_line_core.sv @@
// Testbench for fractional_delay_line_core: directed requests from a table, then random
// phases at several tape lengths, each result checked against a behavioral tape model
// or a typed row's want. Depends on fdl_pkg and the fractional_delay_line_core RTL.
`timescale 1ns / 1ps

module tb_fractional_delay_line_core;

    localparam int SAMPLE_W     = fdl_pkg::SAMPLE_W;
    localparam int DELAY_W      = fdl_pkg::DELAY_W;
    localparam int CFG_LEN_W    = fdl_pkg::CFG_LEN_W;
    localparam int TAPE_DEPTH   = fdl_pkg::TAPE_DEPTH_DEF;
    localparam int FRAC_BITS    = fdl_pkg::FRAC_BITS_DEF;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 235;
    localparam logic [DELAY_W-1:0] DELAY_TOP = 24'hFFFF00;

    typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_LEN_W-1:0]   len;
        logic [SAMPLE_W-1:0]    smp;
        logic [DELAY_W-1:0]     dly;
        logic                   typed;
        logic [SAMPLE_W-1:0]    want;
    } t_stim_row;

    localparam int DIR_N = 28;
    localparam t_stim_row DIR_TBL [DIR_N] = '{
        '{ROW_ITEM, 17'h0,     24'h7FFFFF, 24'h000000, 1'b1, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'h800000, 24'h000100, 1'b1, 24'h7FFFFF},
        '{ROW_ITEM, 17'h0,     24'h000001, 24'h000100, 1'b1, 24'h800000},
        '{ROW_ITEM, 17'h0,     24'h123456, 24'h000180, 1'b0, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'hFFFFFF, 24'hFFFF00, 1'b1, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'h000000, 24'h0003FF, 1'b0, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'h400000, 24'h000001, 1'b0, 24'h000000},
        '{ROW_CFG,  17'h2,     24'h000000, 24'h000000, 1'b0, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'h3FFFFF, 24'h000000, 1'b1, 24'h7FFFFF},
        '{ROW_ITEM, 17'h0,     24'h800000, 24'hFFFF00, 1'b1, 24'h3FFFFF},
        '{ROW_ITEM, 17'h0,     24'h000100, 24'h000080, 1'b0, 24'h000000},
        '{ROW_CFG,  17'h0,     24'h000000, 24'h000000, 1'b0, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'hC00000, 24'h0001FF, 1'b0, 24'h000000},
        '{ROW_CFG,  17'h1,     24'h000000, 24'h000000, 1'b0, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'h000000, 24'h000100, 1'b0, 24'h000000},
        '{ROW_CFG,  17'h1FFFF, 24'h000000, 24'h000000, 1'b0, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'h7FFFFF, 24'h000000, 1'b0, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'h800000, 24'h0000FF, 1'b0, 24'h000000},
        '{ROW_CFG,  17'h3,     24'h000000, 24'h000000, 1'b0, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'h555555, 24'h000280, 1'b0, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'hAAAAAA, 24'h0001C0, 1'b0, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'h7FFFFF, 24'h0002FF, 1'b0, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'h800000, 24'h000180, 1'b0, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'hFFFFFF, 24'h000000, 1'b0, 24'h000000},
        '{ROW_CFG,  17'h10000, 24'h000000, 24'h000000, 1'b0, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'h7FFFFF, 24'h000101, 1'b0, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'h800000, 24'h000180, 1'b0, 24'h000000},
        '{ROW_ITEM, 17'h0,     24'h000000, 24'h0000FF, 1'b0, 24'h000000}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [SAMPLE_W-1:0]   in_sample;
    logic [DELAY_W-1:0]    in_delay;
    logic                  out_valid;
    logic                  out_ready;
    logic [SAMPLE_W-1:0]   out_sample;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_LEN_W-1:0]  cfg_len;

    // Tape model: contents, next write position and the length register.
    logic [SAMPLE_W-1:0]   tape_mdl [TAPE_DEPTH];
    int unsigned           wr_pos;
    logic [CFG_LEN_W-1:0]  len_reg;

    logic [SAMPLE_W-1:0]   delayed_q [$];
    logic [SAMPLE_W-1:0]   exp_sample;
    int                    mismatch_cnt;
    int                    cycle_cnt;
    bit                    idle_en;

    fractional_delay_line_core #(
        .TAPE_DEPTH (TAPE_DEPTH),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_sample          (in_sample),
        .i_delay           (in_delay),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_delayed_sample  (out_sample),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_tape_length (cfg_len)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned eff_len();
        int unsigned len;
        len = len_reg;
        if (len < 2) len = 2;
        if (len > TAPE_DEPTH) len = TAPE_DEPTH;
        return len;
    endfunction

    // Reads the interpolated sample for one request, then records its sample.
    function automatic logic [SAMPLE_W-1:0] interp_tape_read(
        input logic [SAMPLE_W-1:0] smp,
        input logic [DELAY_W-1:0]  dly
    );
        int unsigned       len, w, d, max_d, whole, frac, ia, ib;
        logic [SAMPLE_W-1:0] ua, ub;
        longint unsigned   acc;
        len   = eff_len();
        w     = (wr_pos >= len) ? 0 : wr_pos;
        max_d = (len - 1) << FRAC_BITS;
        d     = (dly > max_d) ? max_d : dly;
        whole = d >> FRAC_BITS;
        frac  = d & ((1 << FRAC_BITS) - 1);
        ia    = (w >= whole) ? w - whole : w + len - whole;
        if (frac != 0)
            ib = (w >= whole + 1) ? w - whole - 1 : w + len - whole - 1;
        else
            ib = ia;
        // Offset binary makes the weighted sum unsigned.
        ua  = tape_mdl[ia] ^ fdl_pkg::SAMPLE_BIAS;
        ub  = tape_mdl[ib] ^ fdl_pkg::SAMPLE_BIAS;
        acc = 64'(ua) * 64'((1 << FRAC_BITS) - frac) + 64'(ub) * 64'(frac)
            + 64'(1 << (FRAC_BITS - 1));
        tape_mdl[w] = smp;
        w = w + 1;
        wr_pos = (w >= len) ? 0 : w;
        return SAMPLE_W'(acc >> FRAC_BITS) ^ fdl_pkg::SAMPLE_BIAS;
    endfunction

    task automatic send_req(
        input logic [SAMPLE_W-1:0] s,
        input logic [DELAY_W-1:0]  d,
        input logic                typed,
        input logic [SAMPLE_W-1:0] want
    );
        logic [SAMPLE_W-1:0] pred;
        if (idle_en) begin
            while ($urandom_range(0, 99) < 20) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid  <= 1'b1;
        in_sample <= s;
        in_delay  <= d;
        do @(posedge clk); while (!in_ready);
        pred = interp_tape_read(s, d);
        delayed_q.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    // The length may only change once the pipeline has drained.
    task automatic write_len(input logic [CFG_LEN_W-1:0] v);
        in_valid <= 1'b0;
        while (delayed_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_len   <= v;
        do @(posedge clk); while (!cfg_ready);
        len_reg = v;
        wr_pos  = 0;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk) begin
        out_ready <= idle_en ? ($urandom_range(0, 99) >= 20) : 1'b1;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (delayed_q.size() == 0) begin
                $display("%0t: result with no request pending, expected none, got %h",
                         $time, out_sample);
                mismatch_cnt++;
            end else begin
                exp_sample = delayed_q.pop_front();
                if (out_sample !== exp_sample) begin
                    $display("%0t: delayed_sample mismatch, expected %h, got %h",
                             $time, exp_sample, out_sample);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [CFG_LEN_W-1:0] plen;
        logic [SAMPLE_W-1:0]  smp;
        logic [DELAY_W-1:0]   dly;
        int unsigned          len, whole, frac, span;
        int                   r;

        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_sample    = '0;
        in_delay     = '0;
        out_ready    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_len      = '0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        idle_en      = 1'b1;
        wr_pos       = 0;
        len_reg      = fdl_pkg::TAPE_LEN_RESET;
        for (int i = 0; i < TAPE_DEPTH; i++) tape_mdl[i] = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_N; i++) begin
            if (DIR_TBL[i].kind == ROW_CFG)
                write_len(DIR_TBL[i].len);
            else
                send_req(DIR_TBL[i].smp, DIR_TBL[i].dly, DIR_TBL[i].typed, DIR_TBL[i].want);
        end

        for (int p = 0; p < 8; p++) begin
            unique case (p)
                0: plen = 17'h10000;
                1: plen = 17'd2;
                2: plen = CFG_LEN_W'($urandom_range(3, 64));
                3: plen = 17'h1FFFF;
                4: plen = CFG_LEN_W'($urandom_range(65, 4096));
                5: plen = CFG_LEN_W'($urandom_range(0, 17'h1FFFF));
                6: plen = 17'd0;
                default: plen = CFG_LEN_W'($urandom_range(3, 300));
            endcase
            write_len(plen);
            // One whole phase runs with both sides streaming.
            idle_en = (p != 3);
            len = eff_len();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 5 && k == PHASE_ITEMS / 2) begin
                    in_valid <= 1'b0;
                    while (delayed_q.size() != 0) @(posedge clk);
                    @(negedge clk);
                end
                r = $urandom_range(0, 99);
                if (r < 10) smp = 24'h7FFFFF;
                else if (r < 20) smp = 24'h800000;
                else smp = SAMPLE_W'($urandom);
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    dly = DELAY_W'($urandom_range(0, DELAY_TOP));
                end else begin
                    if (r < 30) begin
                        whole = len - 1 - $urandom_range(0, 1);
                    end else begin
                        span  = (len - 1 < 300) ? len - 1 : 300;
                        whole = $urandom_range(0, span);
                    end
                    frac = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255);
                    dly  = DELAY_W'((whole << FRAC_BITS) | frac);
                    if ((whole << FRAC_BITS) + frac > DELAY_TOP) dly = DELAY_TOP;
                end
                send_req(smp, dly, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (delayed_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
